/* hdl/hfcc_pkg.sv */
package hfcc_pkg;

    // frame layout and limits
    localparam int HEADER_BYTES  = 24;
    localparam int LENGTH_OFFSET = 20;
    localparam int MAX_PAYLOAD   = 512;

    // character codes used by the hex decode
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] ALPHA_SHIFT = 8'h37;

    // fletcher modulus
    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    // saturation value of the byte counter
    localparam logic [15:0] INDEX_MAX = 16'hFFFF;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] rx_char;
        logic       frame_end;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_length;
    } out_t;

    typedef struct packed {
        logic        pair_phase;
        logic [7:0]  high_char;
        logic [15:0] byte_index;
        logic [7:0]  sum_first;
        logic [7:0]  sum_second;
        logic [15:0] length_value;
        logic [15:0] received_check;
        logic        check_complete;
    } frame_state_t;

    localparam frame_state_t STATE_CLEAR = '0;

    // ascii hex character to value, letters offset by 0x37
    function automatic logic [7:0] decode_char(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else begin
            v = c - ALPHA_SHIFT;
        end
        return v;
    endfunction

    // add two residues below 255 and reduce mod 255
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= FLETCHER_MOD) begin
            s = s - FLETCHER_MOD;
        end
        return s[7:0];
    endfunction

endpackage

/* hdl/hfcc_char_step.sv */
module hfcc_char_step
    import hfcc_pkg::*;
(
    input  frame_state_t state_cur,
    input  logic [7:0]   rx_char,
    output frame_state_t state_upd,
    output out_t         result
);

    logic [7:0]  dec_hi;
    logic [7:0]  dec_lo;
    logic [7:0]  byte_val;
    logic [7:0]  dec_byte;
    logic [3:0]  nib;
    logic [16:0] idx_ext;
    logic [16:0] pay_end;
    logic [16:0] check_off;
    logic [15:0] len_off;
    logic [7:0]  s1;
    logic [15:0] computed;

    // byte assembled from the held high character and this one
    assign dec_hi   = decode_char(state_cur.high_char);
    assign dec_lo   = decode_char(rx_char);
    assign byte_val = {dec_hi[3:0], 4'b0000} | dec_lo;
    assign dec_byte = decode_char(byte_val);
    assign nib      = dec_byte[3:0];

    // positions relative to the length field and the check field
    assign idx_ext   = {1'b0, state_cur.byte_index};
    assign pay_end   = {1'b0, state_cur.length_value} + 17'(HEADER_BYTES);
    assign check_off = idx_ext - pay_end;
    assign len_off   = state_cur.byte_index - 16'(LENGTH_OFFSET);
    assign s1        = add_mod255(state_cur.sum_first, byte_val);

    // state update for one character
    always_comb begin
        state_upd = state_cur;
        if (!state_cur.pair_phase) begin
            state_upd.high_char  = rx_char;
            state_upd.pair_phase = 1'b1;
        end else begin
            state_upd.pair_phase = 1'b0;
            if (state_cur.byte_index >= 16'(LENGTH_OFFSET) &&
                state_cur.byte_index < 16'(LENGTH_OFFSET + 4)) begin
                state_upd.length_value[{len_off[1:0], 2'b00} +: 4] = nib;
            end
            if (idx_ext < pay_end) begin
                state_upd.sum_first  = s1;
                state_upd.sum_second = add_mod255(state_cur.sum_second, s1);
            end else if (check_off < 17'd4 && !state_cur.check_complete) begin
                state_upd.received_check[{check_off[1:0], 2'b00} +: 4] = nib;
                if (check_off[1:0] == 2'd3) begin
                    state_upd.check_complete = 1'b1;
                end
            end
            if (state_cur.byte_index != INDEX_MAX) begin
                state_upd.byte_index = state_cur.byte_index + 16'd1;
            end
        end
    end

    // frame status as it would be reported on this character
    assign computed = {state_upd.sum_second, state_upd.sum_first};

    always_comb begin
        result.payload_length = state_upd.length_value;
        if (state_upd.byte_index < 16'(LENGTH_OFFSET + 4)) begin
            result.status = STATUS_SHORT;
        end else if (state_upd.length_value > 16'(MAX_PAYLOAD)) begin
            result.status = STATUS_TOO_LONG;
        end else if (!state_upd.check_complete) begin
            result.status = STATUS_SHORT;
        end else if (computed == state_upd.received_check) begin
            result.status = STATUS_OK;
        end else begin
            result.status = STATUS_MISMATCH;
        end
    end

endmodule

/* hdl/hex_frame_checksum_checker_top.sv */
// Frame checker for hex-encoded frames: takes one ASCII character per cycle
// on the s_ channel unless input stalls and, on the character flagged
// frame_end, delivers one result (status and decoded payload length) on the
// m_ channel. The only per-character work is a hex decode, two mod-255 adds
// and a few compares between the frame state registers and the result
// register. The result register lets the next frame keep streaming while a
// result waits; input stalls only when a held result is not taken as the
// next frame end arrives. The result is registered and appears in the cycle
// after the last character is accepted; frame state clears at frame end.
module hex_frame_checksum_checker_top
    import hfcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    frame_state_t state_reg, state_next;
    frame_state_t state_upd;
    out_t         result;
    out_t         out_reg;
    logic         out_valid_reg, out_valid_next;
    logic         accept;

    hfcc_char_step u_step (
        .state_cur (state_reg),
        .rx_char   (s_payload.rx_char),
        .state_upd (state_upd),
        .result    (result)
    );

    // a request is taken unless a result is held and a frame end would clobber it
    assign s_ready = !out_valid_reg || m_ready || !s_payload.frame_end;
    assign accept  = s_valid && s_ready;

    // frame state advances per accepted character, clears at frame end
    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = s_payload.frame_end ? STATE_CLEAR : state_upd;
        end
    end

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept && s_payload.frame_end) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept && s_payload.frame_end) begin
            out_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

/* hdl/hfcc_checker.sv */
module hfcc_checker
    import hfcc_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_payload,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // a held result stays until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a new result only follows an accepted frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_payload.frame_end))
        else $error("result without frame end");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input is never blocked while no result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // too-long status only with a length over the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == STATUS_TOO_LONG |->
            m_payload.payload_length > 16'(MAX_PAYLOAD))
        else $error("too-long status with legal length");

endmodule

bind hex_frame_checksum_checker_top hfcc_checker u_hfcc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
